### src/psrp_pkg.sv
// psrp_pkg: shared types and constants of the perf sample record parser
// field codes, configuration register indexes and reset values, channel payloads
// no dependencies
package psrp_pkg;

  localparam int WORD_W    = 64;
  localparam int IDX_W     = 32;
  localparam int CODE_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int UREG_W    = 7;
  localparam int RBLK_W    = 6;

  // count saturation and 8-byte rounding of the stack size
  localparam logic [IDX_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [2:0]       ALIGN_MASK = 3'h7;

  // field codes; FC_HEADER doubles as the idle phase (no record active)
  typedef enum logic [CODE_W-1:0] {
    FC_HEADER      = 5'd0,
    FC_IDENTIFIER  = 5'd1,
    FC_IP          = 5'd2,
    FC_PID_TID     = 5'd3,
    FC_TIME        = 5'd4,
    FC_ADDR        = 5'd5,
    FC_ID          = 5'd6,
    FC_STREAM      = 5'd7,
    FC_CPU_RES     = 5'd8,
    FC_PERIOD      = 5'd9,
    FC_READ        = 5'd10,
    FC_CHAIN_COUNT = 5'd11,
    FC_CHAIN_ENTRY = 5'd12,
    FC_REG_ABI     = 5'd13,
    FC_REG_VALUE   = 5'd14,
    FC_STACK_SIZE  = 5'd15,
    FC_STACK_DATA  = 5'd16,
    FC_STACK_DYN   = 5'd17,
    FC_UNPARSED    = 5'd18
  } field_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_MASK = 2'd0,
    CFG_USER_REGS   = 2'd1,
    CFG_READ_WORDS  = 2'd2
  } cfg_index_t;

  localparam logic [WORD_W-1:0] SAMPLE_MASK_RST = 64'd0;
  localparam logic [UREG_W-1:0] USER_REGS_RST   = 7'd20;
  localparam logic [RBLK_W-1:0] READ_WORDS_RST  = 6'd1;

  typedef struct packed {
    logic [WORD_W-1:0] sample_fields_mask;
    logic [UREG_W-1:0] user_reg_words;
    logic [RBLK_W-1:0] read_block_words;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] record_word;
    logic              record_start;
  } rec_t;

  typedef struct packed {
    field_code_t       field_code;
    logic [WORD_W-1:0] field_word;
    logic [IDX_W-1:0]  element_index;
    logic [WORD_W-1:0] stack_kept_size;
  } res_t;

  typedef struct packed {
    field_code_t      phase;
    logic [IDX_W-1:0] words_left;
    logic [IDX_W-1:0] word_pos;
  } parse_st_t;

endpackage

### src/psrp_rec_if.sv
// psrp_rec_if: record word channel, valid/ready with word and start flag
// depends on psrp_pkg
interface psrp_rec_if;
  logic                      valid;
  logic                      ready;
  logic [psrp_pkg::WORD_W-1:0] record_word;
  logic                      record_start;

  modport source (output valid, output record_word, output record_start, input ready);
  modport sink   (input valid, input record_word, input record_start, output ready);
endinterface

### src/psrp_res_if.sv
// psrp_res_if: tagged result channel, valid/ready with field code, word, index, kept size
// depends on psrp_pkg
interface psrp_res_if;
  logic                          valid;
  logic                          ready;
  psrp_pkg::field_code_t         field_code;
  logic [psrp_pkg::WORD_W-1:0]   field_word;
  logic [psrp_pkg::IDX_W-1:0]    element_index;
  logic [psrp_pkg::WORD_W-1:0]   stack_kept_size;

  modport source (output valid, output field_code, output field_word,
                  output element_index, output stack_kept_size, input ready);
  modport sink   (input valid, input field_code, input field_word,
                  input element_index, input stack_kept_size, output ready);
endinterface

### src/psrp_cfg_if.sv
// psrp_cfg_if: configuration write channel, valid/ready with register index and data
// depends on psrp_pkg
interface psrp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [psrp_pkg::CFG_IDX_W-1:0] reg_index;
  logic [psrp_pkg::WORD_W-1:0]    reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

### src/psrp_cfg_regs.sv
// psrp_cfg_regs: configuration register file of the parser
// depends on psrp_pkg, psrp_cfg_if
module psrp_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  psrp_cfg_if.sink       cfg_ch,
  output psrp_pkg::cfg_t cfg_o
);
  import psrp_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_fields_mask <= SAMPLE_MASK_RST;
      cfg_r.user_reg_words     <= USER_REGS_RST;
      cfg_r.read_block_words   <= READ_WORDS_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_index_t'(cfg_ch.reg_index))
        CFG_SAMPLE_MASK: cfg_r.sample_fields_mask <= cfg_ch.reg_data;
        CFG_USER_REGS:   cfg_r.user_reg_words     <= cfg_ch.reg_data[UREG_W-1:0];
        CFG_READ_WORDS:  cfg_r.read_block_words   <= cfg_ch.reg_data[RBLK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### src/psrp_in_reg.sv
// psrp_in_reg: input register stage holding one record word
// depends on psrp_pkg, psrp_rec_if
module psrp_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  psrp_rec_if.sink       in_ch,
  input  logic           take,
  output logic           s1_valid,
  output psrp_pkg::rec_t s1_rec
);
  import psrp_pkg::*;

  logic s1_valid_r;
  rec_t s1_rec_r;

  // stage frees up in the same cycle its word moves on
  assign in_ch.ready = !s1_valid_r || take;
  assign s1_valid    = s1_valid_r;
  assign s1_rec      = s1_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_rec_r.record_word  <= in_ch.record_word;
      s1_rec_r.record_start <= in_ch.record_start;
    end
  end

endmodule

### src/psrp_parse.sv
// psrp_parse: parse state and field tagging for one record word per cycle while take is high
// depends on psrp_pkg
module psrp_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  psrp_pkg::rec_t rec,
  input  psrp_pkg::cfg_t cfg,
  output psrp_pkg::res_t res
);
  import psrp_pkg::*;

  parse_st_t         st_r, st_nxt;
  logic [WORD_W-1:0] static_size_r, static_size_nxt;
  logic [IDX_W-1:0]  wl_dec;
  logic [61:0]       stack_words;

  function automatic logic [IDX_W-1:0] sat32(logic [WORD_W-1:0] v);
    return (v > WORD_W'(COUNT_MAX)) ? COUNT_MAX : v[IDX_W-1:0];
  endfunction

  // first enabled field after 'from', in fixed field order
  function automatic parse_st_t go_next(field_code_t from, cfg_t c);
    logic [17:0] en;
    parse_st_t   s;
    en      = '0;
    en[1]   = c.sample_fields_mask[16];
    en[2]   = c.sample_fields_mask[0];
    en[3]   = c.sample_fields_mask[1];
    en[4]   = c.sample_fields_mask[2];
    en[5]   = c.sample_fields_mask[3];
    en[6]   = c.sample_fields_mask[6];
    en[7]   = c.sample_fields_mask[9];
    en[8]   = c.sample_fields_mask[7];
    en[9]   = c.sample_fields_mask[8];
    en[10]  = c.sample_fields_mask[4] && (c.read_block_words != '0);
    en[11]  = c.sample_fields_mask[5];
    en[13]  = c.sample_fields_mask[12];
    en[15]  = c.sample_fields_mask[13];
    s.phase      = FC_UNPARSED;
    s.words_left = '0;
    s.word_pos   = '0;
    for (int i = 17; i >= 1; i--) begin
      if (en[i] && (i > int'(from))) begin
        s.phase = field_code_t'(CODE_W'(i));
      end
    end
    if (s.phase == FC_READ) begin
      s.words_left = IDX_W'(c.read_block_words);
    end
    return s;
  endfunction

  // open a block of n words, or skip past it when empty
  function automatic parse_st_t enter_blk(field_code_t ph, logic [IDX_W-1:0] n,
                                          field_code_t skip, cfg_t c);
    parse_st_t s;
    s.phase      = ph;
    s.words_left = n;
    s.word_pos   = '0;
    if (n == '0) begin
      s = go_next(skip, c);
    end
    return s;
  endfunction

  assign wl_dec      = st_r.words_left - 32'd1;
  // stack size in words, rounded up to a whole word
  assign stack_words = {1'b0, rec.record_word[63:3]}
                     + 62'(|(rec.record_word[2:0] & ALIGN_MASK));

  always_comb begin
    st_nxt              = st_r;
    static_size_nxt     = static_size_r;
    res.field_code      = FC_UNPARSED;
    res.field_word      = rec.record_word;
    res.element_index   = '0;
    res.stack_kept_size = '0;
    if (rec.record_start) begin
      res.field_code = FC_HEADER;
      st_nxt         = go_next(FC_HEADER, cfg);
    end else if (st_r.phase == FC_HEADER || st_r.phase >= FC_UNPARSED) begin
      res.field_code = FC_UNPARSED;
    end else begin
      res.field_code = st_r.phase;
      case (st_r.phase)
        FC_READ, FC_CHAIN_ENTRY, FC_REG_VALUE, FC_STACK_DATA: begin
          res.element_index = st_r.word_pos;
          st_nxt.word_pos   = st_r.word_pos + 32'd1;
          st_nxt.words_left = wl_dec;
          if (wl_dec == '0) begin
            if (st_r.phase == FC_STACK_DATA) begin
              st_nxt.phase    = FC_STACK_DYN;
              st_nxt.word_pos = '0;
            end else begin
              st_nxt = go_next(st_r.phase, cfg);
            end
          end
        end
        FC_CHAIN_COUNT: begin
          st_nxt = enter_blk(FC_CHAIN_ENTRY, sat32(rec.record_word), FC_CHAIN_ENTRY, cfg);
        end
        FC_REG_ABI: begin
          st_nxt = enter_blk(FC_REG_VALUE, IDX_W'(cfg.user_reg_words), FC_REG_VALUE, cfg);
        end
        FC_STACK_SIZE: begin
          static_size_nxt = rec.record_word;
          if (rec.record_word == '0) begin
            st_nxt = go_next(FC_STACK_DYN, cfg);
          end else begin
            st_nxt = enter_blk(FC_STACK_DATA, sat32(WORD_W'(stack_words)),
                               FC_STACK_DYN, cfg);
          end
        end
        FC_STACK_DYN: begin
          res.stack_kept_size = (static_size_r < rec.record_word) ? '0 : rec.record_word;
          st_nxt              = go_next(FC_STACK_DYN, cfg);
        end
        default: begin
          st_nxt = go_next(st_r.phase, cfg);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= FC_HEADER;
      st_r.words_left <= '0;
      st_r.word_pos   <= '0;
      static_size_r   <= '0;
    end else if (take) begin
      st_r          <= st_nxt;
      static_size_r <= static_size_nxt;
    end
  end

endmodule

### src/psrp_out_reg.sv
// psrp_out_reg: result register driving the tagged result channel
// depends on psrp_pkg, psrp_res_if
module psrp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  psrp_pkg::res_t res,
  output logic           free,
  psrp_res_if.source     out_ch
);
  import psrp_pkg::*;

  logic out_valid_r;
  res_t res_r;

  assign free                   = !out_valid_r || out_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.field_code      = res_r.field_code;
  assign out_ch.field_word      = res_r.field_word;
  assign out_ch.element_index   = res_r.element_index;
  assign out_ch.stack_kept_size = res_r.stack_kept_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

endmodule

### src/perf_sample_record_parser_top.sv
// perf_sample_record_parser_top: perf sample record word tagger, top level
// depends on psrp_pkg, the channel interfaces, psrp_cfg_regs, psrp_in_reg,
// psrp_parse and psrp_out_reg
//
// usage
//   in_ch  : record words, one 64-bit word per transfer; record_start marks the
//            header word and always restarts parsing
//   out_ch : one tagged word per input word, same order: field code, the word
//            itself, index inside multi-word fields, kept stack size on the
//            dynamic-size word
//   cfg_ch : register writes (0 sample field mask, 1 user register words,
//            2 read block words); always ready, write only while idle
// timing
//   an accepted word passes the input register, then the result register, to out_ch
//   one word per cycle sustained while out_ch is ready; the field search is a
//   priority pick over the mask, combinational between input and result register
// reset
//   synchronous, active low; clears both stage valids and the parse state,
//   registers return to mask 0, 20 user register words, 1 read block word
// stall
//   if out_ch is held, the result register keeps its word; the input register
//   takes one more word only if it was empty, then in_ch ready drops
module perf_sample_record_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  psrp_rec_if.sink   in_ch,
  psrp_res_if.source out_ch,
  psrp_cfg_if.sink   cfg_ch
);
  import psrp_pkg::*;

  cfg_t cfg;
  rec_t s1_rec;
  res_t res;
  logic s1_valid;
  logic out_free;
  logic take;

  // word in the input register moves to the result register
  assign take = s1_valid && out_free;

  psrp_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  psrp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_rec   (s1_rec)
  );

  // parse state advances only when a word is handed to the result register
  psrp_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .rec   (s1_rec),
    .cfg   (cfg),
    .res   (res)
  );

  psrp_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

### src/psrp_checker.sv
// psrp_checker: port-level checks of the parser result channel, bound to the top
// depends on psrp_pkg, perf_sample_record_parser_top
module psrp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [psrp_pkg::CODE_W-1:0]   field_code,
  input logic [psrp_pkg::WORD_W-1:0]   field_word,
  input logic [psrp_pkg::IDX_W-1:0]    element_index,
  input logic [psrp_pkg::WORD_W-1:0]   stack_kept_size
);
  import psrp_pkg::*;

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(field_code) && $stable(field_word)
      && $stable(element_index) && $stable(stack_kept_size))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // index only inside multi-word fields
  a_index_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (element_index != '0) |->
      (field_code == FC_READ) || (field_code == FC_CHAIN_ENTRY)
      || (field_code == FC_REG_VALUE) || (field_code == FC_STACK_DATA))
    else $error("element index on single-word field");

  // kept stack size only on the dynamic-size word
  a_kept_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (stack_kept_size != '0) |->
      (field_code == FC_STACK_DYN) && (stack_kept_size == field_word))
    else $error("kept stack size on wrong field");

endmodule

bind perf_sample_record_parser_top psrp_checker u_psrp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .field_code      (out_ch.field_code),
  .field_word      (out_ch.field_word),
  .element_index   (out_ch.element_index),
  .stack_kept_size (out_ch.stack_kept_size)
);
